/* hdl/gamepad_radial_deadzone_defines.svh */
// assertion macros for the gamepad radial dead zone block
`ifndef GAMEPAD_RADIAL_DEADZONE_DEFINES_SVH
`define GAMEPAD_RADIAL_DEADZONE_DEFINES_SVH

// checked outside reset
`define GRD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gamepad radial deadzone check failed");

// checked on every edge, reset included
`define GRD_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("gamepad radial deadzone reset check failed");

`endif

/* hdl/grd_pkg.sv */
// shared types and constants of the gamepad radial dead zone block
`timescale 1ns / 1ps
package grd_pkg;

   localparam int unsigned FRAC_BITS_DEF = 14;
   localparam int unsigned QUO_BITS      = 17;
   localparam int unsigned SQ_STAGES     = 16;
   localparam int unsigned BACK_DEPTH    = SQ_STAGES + QUO_BITS + 3;
   localparam int unsigned QUEUE_DEPTH   = 4;

   typedef enum logic [1:0] {
      CSR_LEFT_DZ  = 2'd0,
      CSR_RIGHT_DZ = 2'd1,
      CSR_TRIG_TH  = 2'd2
   } csr_index_type;

   localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
   localparam logic [7:0]  TRIG_TH_RST  = 8'd30;
   localparam logic [14:0] DZ_MAX       = 15'd32766;
   localparam logic [15:0] AXIS_FULL    = 16'd32767;
   localparam logic [7:0]  TRIG_FULL    = 8'd255;

   typedef struct packed {
      logic [31:0] sum_sq;
      logic [15:0] abs_x;
      logic [15:0] abs_y;
      logic        neg_x;
      logic        neg_y;
   } stick_type;

   typedef struct packed {
      logic [7:0] num;
      logic [7:0] den;
   } trig_type;

   typedef struct packed {
      stick_type   left;
      stick_type   right;
      trig_type    trig_l;
      trig_type    trig_r;
      logic [15:0] buttons;
   } entry_type;

endpackage

/* hdl/grd_front.sv */
// input stage: takes a sample, forms squared magnitudes and trigger terms
`timescale 1ns / 1ps
module grd_front import grd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic signed [15:0] req_left_raw_x,
   input  logic signed [15:0] req_left_raw_y,
   input  logic signed [15:0] req_right_raw_x,
   input  logic signed [15:0] req_right_raw_y,
   input  logic [7:0]        req_left_trigger_raw,
   input  logic [7:0]        req_right_trigger_raw,
   input  logic [15:0]       req_button_bits,
   input  logic [7:0]        trig_th,
   output logic              q_push,
   output entry_type         q_data,
   input  logic              q_full
);

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;
   logic      take;

   function automatic logic [15:0] abs16(logic [15:0] v);
      return v[15] ? 16'(~v) + 16'd1 : v;
   endfunction

   function automatic stick_type make_stick(logic [15:0] x, logic [15:0] y);
      stick_type s;
      s.abs_x  = abs16(x);
      s.abs_y  = abs16(y);
      s.neg_x  = x[15];
      s.neg_y  = y[15];
      s.sum_sq = 32'(s.abs_x) * 32'(s.abs_x) + 32'(s.abs_y) * 32'(s.abs_y);
      return s;
   endfunction

   function automatic trig_type make_trig(logic [7:0] t, logic [7:0] th);
      trig_type r;
      if (t > th) begin
         r.num = t - th;
         r.den = TRIG_FULL - th;
      end else begin
         r.num = 8'd0;
         r.den = 8'd1;
      end
      return r;
   endfunction

   assign full   = valid_ff && q_full;
   assign take   = push && !full;
   assign q_push = valid_ff && !q_full;
   assign q_data = data_ff;

   assign valid_in = take || (valid_ff && q_full);

   always_comb begin
      data_in         = data_ff;
      data_in.left    = make_stick(req_left_raw_x, req_left_raw_y);
      data_in.right   = make_stick(req_right_raw_x, req_right_raw_y);
      data_in.trig_l  = make_trig(req_left_trigger_raw, trig_th);
      data_in.trig_r  = make_trig(req_right_trigger_raw, trig_th);
      data_in.buttons = req_button_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hdl/grd_queue.sv */
// short word queue between the front and back parts
`timescale 1ns / 1ps
module grd_queue import grd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   output logic      full,
   input  entry_type data_in,
   input  logic      pop,
   output logic      empty,
   output entry_type data_out
);

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

/* hdl/grd_isqrt.sv */
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module grd_isqrt import grd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] sq_in,
   output logic [15:0] root_out
);

   logic [18:0] rem_ff  [SQ_STAGES];
   logic [18:0] rem_in  [SQ_STAGES];
   logic [15:0] root_ff [SQ_STAGES];
   logic [15:0] root_in [SQ_STAGES];
   logic [31:0] rest_ff [SQ_STAGES];
   logic [31:0] rest_in [SQ_STAGES];

   always_comb begin
      logic [18:0] p_rem;
      logic [15:0] p_root;
      logic [31:0] p_rest;
      logic [18:0] shifted;
      logic [18:0] trial;
      for (int k = 0; k < SQ_STAGES; k++) begin
         if (k == 0) begin
            p_rem  = '0;
            p_root = '0;
            p_rest = sq_in;
         end else begin
            p_rem  = rem_ff[k-1];
            p_root = root_ff[k-1];
            p_rest = rest_ff[k-1];
         end
         shifted    = {p_rem[16:0], p_rest[31:30]};
         trial      = {1'b0, p_root, 2'b01};
         rest_in[k] = {p_rest[29:0], 2'b00};
         if (shifted >= trial) begin
            rem_in[k]  = shifted - trial;
            root_in[k] = {p_root[14:0], 1'b1};
         end else begin
            rem_in[k]  = shifted;
            root_in[k] = {p_root[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQ_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rest_ff[k] <= rest_in[k];
         end
      end
   end

   assign root_out = root_ff[SQ_STAGES-1];

endmodule

/* hdl/grd_div.sv */
// pipelined restoring divider with quotient overflow flag
`timescale 1ns / 1ps
module grd_div import grd_pkg::*; #(
   parameter int unsigned NUM_W = 48,
   parameter int unsigned DEN_W = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_W-1:0]    num_in,
   input  logic [DEN_W-1:0]    den_in,
   output logic [QUO_BITS-1:0] quo_out,
   output logic                ovf_out
);

   localparam int unsigned QW = QUO_BITS;
   localparam int unsigned CW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

   logic [CW-1:0]    rem_ff [QW+1];
   logic [CW-1:0]    rem_in [QW+1];
   logic [DEN_W-1:0] den_ff [QW+1];
   logic [QW-1:0]    quo_ff [QW+1];
   logic [QW-1:0]    quo_in [QW+1];
   logic             ovf_ff [QW+1];
   logic             ovf_in;

   assign ovf_in = CW'(num_in) >= (CW'(den_in) << QW);

   always_comb begin
      logic [CW-1:0] sub;
      rem_in[0] = CW'(num_in);
      quo_in[0] = '0;
      for (int j = 1; j <= QW; j++) begin
         sub       = CW'(den_ff[j-1]) << (QW - j);
         quo_in[j] = quo_ff[j-1];
         if (rem_ff[j-1] >= sub) begin
            rem_in[j]          = rem_ff[j-1] - sub;
            quo_in[j][QW - j]  = 1'b1;
         end else begin
            rem_in[j] = rem_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         den_ff[0] <= den_in;
         quo_ff[0] <= quo_in[0];
         ovf_ff[0] <= ovf_in;
         for (int j = 1; j <= QW; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_ff[j-1];
            quo_ff[j] <= quo_in[j];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo_out = quo_ff[QW];
   assign ovf_out = ovf_ff[QW];

endmodule

/* hdl/grd_back.sv */
// back pipeline: square roots, scale products, divisions and output register
`timescale 1ns / 1ps
module grd_back import grd_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   output logic              q_pop,
   input  logic              q_empty,
   input  entry_type         q_data,
   input  logic [14:0]       dz_left,
   input  logic [14:0]       dz_right,
   output logic              empty,
   input  logic              pop,
   output logic signed [15:0] rsp_left_out_x,
   output logic signed [15:0] rsp_left_out_y,
   output logic signed [15:0] rsp_right_out_x,
   output logic signed [15:0] rsp_right_out_y,
   output logic [14:0]       rsp_left_trigger_level,
   output logic [14:0]       rsp_right_trigger_level,
   output logic [15:0]       rsp_button_state
);

   localparam int unsigned PASS_DEPTH = BACK_DEPTH - 1;
   localparam int unsigned SNUM_W     = 32 + FRAC_BITS + 2;
   localparam int unsigned TNUM_W     = 8 + FRAC_BITS + 2;

   typedef struct packed {
      logic [31:0] numx;
      logic [31:0] numy;
      logic [30:0] den;
   } prod_type;

   logic [BACK_DEPTH-1:0] vld_ff;
   logic                  adv;
   entry_type             pass_ff [PASS_DEPTH];
   logic [15:0]           root_l, root_r;
   prod_type              prod_l_ff, prod_r_ff, prod_l_in, prod_r_in;
   entry_type             tail;
   trig_type              trg_l, trg_r;

   logic [QUO_BITS-1:0]   q_lx, q_ly, q_rx, q_ry, q_tl, q_tr;
   logic                  o_lx, o_ly, o_rx, o_ry, o_tl, o_tr;

   logic [15:0] lx_ff, ly_ff, rx_ff, ry_ff, bt_ff;
   logic [14:0] tl_ff, tr_ff;

   function automatic prod_type make_prod(logic [15:0] root, stick_type s, logic [14:0] dz_raw);
      prod_type    p;
      logic [14:0] dz;
      logic [15:0] diff;
      logic [14:0] dent;
      dz   = (dz_raw > DZ_MAX) ? DZ_MAX : dz_raw;
      diff = root - 16'(dz);
      dent = 15'(AXIS_FULL) - dz;
      if (root <= 16'(dz)) begin
         p.numx = '0;
         p.numy = '0;
         p.den  = 31'd1;
      end else begin
         p.numx = 32'(s.abs_x) * 32'(diff);
         p.numy = 32'(s.abs_y) * 32'(diff);
         p.den  = 31'(root) * 31'(dent);
      end
      return p;
   endfunction

   function automatic logic [15:0] fmt_axis(logic [QUO_BITS-1:0] q, logic ovf, logic negative);
      logic [QUO_BITS-1:0] m;
      m = q;
      if (negative) begin
         if (ovf || q > QUO_BITS'(32768)) begin
            m = QUO_BITS'(32768);
         end
         return 16'(~m + 1'b1);
      end
      if (ovf || q > QUO_BITS'(AXIS_FULL)) begin
         m = QUO_BITS'(AXIS_FULL);
      end
      return 16'(m);
   endfunction

   function automatic logic [14:0] fmt_trig(logic [QUO_BITS-1:0] q, logic ovf);
      return (ovf || q > QUO_BITS'(AXIS_FULL)) ? 15'h7fff : 15'(q);
   endfunction

   assign adv   = !vld_ff[BACK_DEPTH-1] || pop;
   assign q_pop = adv && !q_empty;
   assign empty = !vld_ff[BACK_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[BACK_DEPTH-2:0], q_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pass_ff[0] <= q_data;
         for (int k = 1; k < PASS_DEPTH; k++) begin
            pass_ff[k] <= pass_ff[k-1];
         end
      end
   end

   grd_isqrt u_sqrt_l (
      .clock    (clock),
      .en       (adv),
      .sq_in    (q_data.left.sum_sq),
      .root_out (root_l)
   );

   grd_isqrt u_sqrt_r (
      .clock    (clock),
      .en       (adv),
      .sq_in    (q_data.right.sum_sq),
      .root_out (root_r)
   );

   // scale products
   assign prod_l_in = make_prod(root_l, pass_ff[SQ_STAGES-1].left, dz_left);
   assign prod_r_in = make_prod(root_r, pass_ff[SQ_STAGES-1].right, dz_right);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
   end

   assign trg_l = pass_ff[SQ_STAGES].trig_l;
   assign trg_r = pass_ff[SQ_STAGES].trig_r;

   grd_div #(.NUM_W(SNUM_W), .DEN_W(32)) u_div_lx (
      .clock   (clock),
      .en      (adv),
      .num_in  ((SNUM_W'(prod_l_ff.numx) << (FRAC_BITS + 1)) + SNUM_W'(prod_l_ff.den)),
      .den_in  ({prod_l_ff.den, 1'b0}),
      .quo_out (q_lx),
      .ovf_out (o_lx)
   );

   grd_div #(.NUM_W(SNUM_W), .DEN_W(32)) u_div_ly (
      .clock   (clock),
      .en      (adv),
      .num_in  ((SNUM_W'(prod_l_ff.numy) << (FRAC_BITS + 1)) + SNUM_W'(prod_l_ff.den)),
      .den_in  ({prod_l_ff.den, 1'b0}),
      .quo_out (q_ly),
      .ovf_out (o_ly)
   );

   grd_div #(.NUM_W(SNUM_W), .DEN_W(32)) u_div_rx (
      .clock   (clock),
      .en      (adv),
      .num_in  ((SNUM_W'(prod_r_ff.numx) << (FRAC_BITS + 1)) + SNUM_W'(prod_r_ff.den)),
      .den_in  ({prod_r_ff.den, 1'b0}),
      .quo_out (q_rx),
      .ovf_out (o_rx)
   );

   grd_div #(.NUM_W(SNUM_W), .DEN_W(32)) u_div_ry (
      .clock   (clock),
      .en      (adv),
      .num_in  ((SNUM_W'(prod_r_ff.numy) << (FRAC_BITS + 1)) + SNUM_W'(prod_r_ff.den)),
      .den_in  ({prod_r_ff.den, 1'b0}),
      .quo_out (q_ry),
      .ovf_out (o_ry)
   );

   grd_div #(.NUM_W(TNUM_W), .DEN_W(9)) u_div_tl (
      .clock   (clock),
      .en      (adv),
      .num_in  ((TNUM_W'(trg_l.num) << (FRAC_BITS + 1)) + TNUM_W'(trg_l.den)),
      .den_in  ({trg_l.den, 1'b0}),
      .quo_out (q_tl),
      .ovf_out (o_tl)
   );

   grd_div #(.NUM_W(TNUM_W), .DEN_W(9)) u_div_tr (
      .clock   (clock),
      .en      (adv),
      .num_in  ((TNUM_W'(trg_r.num) << (FRAC_BITS + 1)) + TNUM_W'(trg_r.den)),
      .den_in  ({trg_r.den, 1'b0}),
      .quo_out (q_tr),
      .ovf_out (o_tr)
   );

   // signs applied on the magnitude, y axes negated
   assign tail = pass_ff[PASS_DEPTH-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         lx_ff <= fmt_axis(q_lx, o_lx, tail.left.neg_x);
         ly_ff <= fmt_axis(q_ly, o_ly, !tail.left.neg_y);
         rx_ff <= fmt_axis(q_rx, o_rx, tail.right.neg_x);
         ry_ff <= fmt_axis(q_ry, o_ry, !tail.right.neg_y);
         tl_ff <= fmt_trig(q_tl, o_tl);
         tr_ff <= fmt_trig(q_tr, o_tr);
         bt_ff <= tail.buttons;
      end
   end

   assign rsp_left_out_x          = lx_ff;
   assign rsp_left_out_y          = ly_ff;
   assign rsp_right_out_x         = rx_ff;
   assign rsp_right_out_y         = ry_ff;
   assign rsp_left_trigger_level  = tl_ff;
   assign rsp_right_trigger_level = tr_ff;
   assign rsp_button_state        = bt_ff;

endmodule

/* hdl/gamepad_radial_deadzone.sv */
// top level of the gamepad radial dead zone conditioner
//
//   channel   handshake          payload
//   req       push / full        four stick axes, two triggers, buttons
//   rsp       empty / pop        four scaled axes, two trigger levels, buttons
//   csr       valid / ready      csr_index, csr_data
//
// one word per cycle in and out while the back pipeline is not stalled
// the back pipeline holds the 16-stage square root and 18-stage divider pipeline
// a word in the output register that is not popped stalls the back pipeline,
// a four-word queue lets the input stage keep taking words meanwhile
// synchronous reset clears control state and loads the csr defaults
`timescale 1ns / 1ps
module gamepad_radial_deadzone import grd_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic signed [15:0] req_left_raw_x,
   input  logic signed [15:0] req_left_raw_y,
   input  logic signed [15:0] req_right_raw_x,
   input  logic signed [15:0] req_right_raw_y,
   input  logic [7:0]        req_left_trigger_raw,
   input  logic [7:0]        req_right_trigger_raw,
   input  logic [15:0]       req_button_bits,
   output logic              empty,
   input  logic              pop,
   output logic signed [15:0] rsp_left_out_x,
   output logic signed [15:0] rsp_left_out_y,
   output logic signed [15:0] rsp_right_out_x,
   output logic signed [15:0] rsp_right_out_y,
   output logic [14:0]       rsp_left_trigger_level,
   output logic [14:0]       rsp_right_trigger_level,
   output logic [15:0]       rsp_button_state,
   input  logic              valid,
   output logic              ready,
   input  logic [1:0]        csr_index,
   input  logic [14:0]       csr_data
);

   logic [14:0] dz_left_ff, dz_right_ff;
   logic [7:0]  trig_th_ff;
   logic        fq_push, fq_full, bq_pop, bq_empty;
   entry_type   fq_data, bq_data;

   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_left_ff  <= LEFT_DZ_RST;
         dz_right_ff <= RIGHT_DZ_RST;
         trig_th_ff  <= TRIG_TH_RST;
      end else if (valid && ready) begin
         case (csr_index)
            CSR_LEFT_DZ: begin
               dz_left_ff <= csr_data;
            end
            CSR_RIGHT_DZ: begin
               dz_right_ff <= csr_data;
            end
            CSR_TRIG_TH: begin
               trig_th_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   grd_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_left_raw_x        (req_left_raw_x),
      .req_left_raw_y        (req_left_raw_y),
      .req_right_raw_x       (req_right_raw_x),
      .req_right_raw_y       (req_right_raw_y),
      .req_left_trigger_raw  (req_left_trigger_raw),
      .req_right_trigger_raw (req_right_trigger_raw),
      .req_button_bits       (req_button_bits),
      .trig_th               (trig_th_ff),
      .q_push                (fq_push),
      .q_data                (fq_data),
      .q_full                (fq_full)
   );

   grd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .full     (fq_full),
      .data_in  (fq_data),
      .pop      (bq_pop),
      .empty    (bq_empty),
      .data_out (bq_data)
   );

   grd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_pop                   (bq_pop),
      .q_empty                 (bq_empty),
      .q_data                  (bq_data),
      .dz_left                 (dz_left_ff),
      .dz_right                (dz_right_ff),
      .empty                   (empty),
      .pop                     (pop),
      .rsp_left_out_x          (rsp_left_out_x),
      .rsp_left_out_y          (rsp_left_out_y),
      .rsp_right_out_x         (rsp_right_out_x),
      .rsp_right_out_y         (rsp_right_out_y),
      .rsp_left_trigger_level  (rsp_left_trigger_level),
      .rsp_right_trigger_level (rsp_right_trigger_level),
      .rsp_button_state        (rsp_button_state)
   );

endmodule

/* hdl/grd_checker.sv */
// port checker for the gamepad radial dead zone block, bound to the top level
`timescale 1ns / 1ps
`include "gamepad_radial_deadzone_defines.svh"
module grd_checker (
   input logic              clock,
   input logic              reset,
   input logic              push,
   input logic              full,
   input logic signed [15:0] req_left_raw_x,
   input logic signed [15:0] req_left_raw_y,
   input logic signed [15:0] req_right_raw_x,
   input logic signed [15:0] req_right_raw_y,
   input logic [7:0]        req_left_trigger_raw,
   input logic [7:0]        req_right_trigger_raw,
   input logic [15:0]       req_button_bits,
   input logic              empty,
   input logic              pop,
   input logic signed [15:0] rsp_left_out_x,
   input logic signed [15:0] rsp_left_out_y,
   input logic signed [15:0] rsp_right_out_x,
   input logic signed [15:0] rsp_right_out_y,
   input logic [14:0]       rsp_left_trigger_level,
   input logic [14:0]       rsp_right_trigger_level,
   input logic [15:0]       rsp_button_state,
   input logic              valid,
   input logic              ready,
   input logic [1:0]        csr_index,
   input logic [14:0]       csr_data
);

   `GRD_ASSERT_RST(a_reset_clears, reset |=> empty && !full)
   `GRD_ASSERT_RST(a_csr_always_ready, ready)
   `GRD_ASSERT(a_word_held, !empty && !pop |=> !empty)
   `GRD_ASSERT(a_word_stable, !empty && !pop |=> $stable(rsp_left_out_x) && $stable(rsp_button_state))

endmodule

bind gamepad_radial_deadzone grd_checker u_grd_checker (.*);
